// File: hdl/sample_voice_mixer_macros.svh
// assertion helpers shared by the mixer rtl
`ifndef SAMPLE_VOICE_MIXER_MACROS_SVH
`define SAMPLE_VOICE_MIXER_MACROS_SVH

// same-cycle implication
`define SVM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SVM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/svm_pkg.sv
package svm_pkg;

  localparam int SAMPLE_DEPTH  = 16384;
  localparam int FRACTION_BITS = 16;
  localparam int ADDR_W        = $clog2(SAMPLE_DEPTH);
  localparam int INT_W         = 15;
  localparam int POS_W         = INT_W + FRACTION_BITS;
  localparam int STEP_UP       = (FRACTION_BITS > 16) ? FRACTION_BITS - 16 : 0;
  localparam int STEP_DOWN     = (FRACTION_BITS < 16) ? 16 - FRACTION_BITS : 0;
  localparam int PITCH_W       = 19;
  localparam int STEP_W        = PITCH_W + STEP_UP;
  localparam int IDX_EXT_W     = (ADDR_W > INT_W) ? ADDR_W : INT_W;
  localparam int LDA_W         = 14;
  localparam int LDA_EXT_W     = (ADDR_W > LDA_W) ? ADDR_W : LDA_W;
  localparam int SAMPLE_W      = 16;
  localparam int MUL_W         = 17;
  localparam int PROD_W        = 2 * MUL_W;
  localparam int SUM_W         = 18;
  localparam int CFG_W         = 19;
  localparam int CFG_IDX_W     = 3;
  localparam int VOL_SHIFT     = 15;
  localparam int GAIN_SHIFT    = 14;

  localparam logic [15:0]        UNITY_VOLUME = 16'd32768;
  localparam logic [15:0]        MAX_GAIN     = 16'd32768;
  localparam logic [PITCH_W-1:0] PITCH_MIN    = 19'd16384;
  localparam logic [PITCH_W-1:0] PITCH_MAX    = 19'd262144;

  localparam logic [15:0]        VOLUME_RST = 16'd32768;
  localparam logic [PITCH_W-1:0] PITCH_RST  = 19'd65536;
  localparam logic [15:0]        GAIN_RST   = 16'd8192;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_START = 2'd1,
    ACT_HALT  = 2'd2,
    ACT_MIX   = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VOLUME     = 3'd0,
    CFG_PITCH_STEP = 3'd1,
    CFG_LEFT_GAIN  = 3'd2,
    CFG_RIGHT_GAIN = 3'd3,
    CFG_LENGTH     = 3'd4,
    CFG_LOOP       = 3'd5,
    CFG_PAUSE      = 3'd6
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_VOL,
    S_SCALE,
    S_LEFT,
    S_RIGHT,
    S_FINISH,
    S_DONE
  } fsm_state_t;

  typedef struct packed {
    action_t            action;
    logic [LDA_W-1:0]   load_address;
    logic signed [15:0] load_value;
    logic signed [15:0] left_in;
    logic signed [15:0] right_in;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
    logic               playing;
  } out_item_t;

  // product scaled down with rounding toward zero
  function automatic logic signed [PROD_W-1:0] trunc_q(input logic signed [PROD_W-1:0] p,
                                                       input int sh);
    logic signed [PROD_W-1:0] bias;
    bias = p[PROD_W-1] ? ((PROD_W'(1) <<< sh) - PROD_W'(1)) : '0;
    return (p + bias) >>> sh;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [SUM_W-1:0] x);
    logic signed [15:0] r;
    if (x > SUM_W'(32767)) begin
      r = 16'sh7fff;
    end else if (x < -SUM_W'(32768)) begin
      r = 16'sh8000;
    end else begin
      r = x[15:0];
    end
    return r;
  endfunction

endpackage

// File: hdl/svm_ram.sv
module svm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/sample_voice_mixer.sv
// mix item with a running voice: result registered via states S_VOL to S_DONE,
// next item taken the cycle after; one shared 17x17 multiplier is used three times
// load, start, halt and pass-through mix items: result registered via S_DONE
// a pending result waits in the output register while the next item is taken
// synchronous active-low reset clears control, position, active and output valid,
// loads voice setting defaults; the sample store has no reset
module sample_voice_mixer
  import svm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  `include "sample_voice_mixer_macros.svh"

  fsm_state_t state_r, state_nxt;

  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic               active_r, active_nxt;
  logic [15:0]        volume_r, volume_nxt;
  logic [PITCH_W-1:0] pitch_r, pitch_nxt;
  logic [15:0]        lgain_r, lgain_nxt;
  logic [15:0]        rgain_r, rgain_nxt;
  logic [INT_W-1:0]   length_r, length_nxt;
  logic               loop_r, loop_nxt;
  logic               pause_r, pause_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;

  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [MUL_W-1:0]  scaled_r, scaled_nxt;
  logic signed [15:0]       left_r, left_nxt;
  logic signed [15:0]       right_r, right_nxt;

  logic                     in_xfer;
  logic                     cfg_xfer;
  logic                     out_free;
  logic                     mix_go;
  logic                     mix_stop;
  logic                     at_end;
  logic                     run;
  logic [INT_W-1:0]         pos_int;
  logic [POS_W-1:0]         pos_base;
  logic [POS_W:0]           pos_sum;
  logic [POS_W-1:0]         pos_adv;
  logic [PITCH_W-1:0]       pitch_c;
  logic [STEP_W-1:0]        step_fx;
  logic [IDX_EXT_W-1:0]     idx_ext;
  logic [LDA_EXT_W-1:0]     lda_ext;
  logic [15:0]              vol_c, lg_c, rg_c;
  logic [1:0]               mul_sel;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [SUM_W-1:0]  side_sum;

  logic                ram_wr_en;
  logic [ADDR_W-1:0]   ram_wr_addr;
  logic                ram_rd_en;
  logic [ADDR_W-1:0]   ram_rd_addr;
  logic [SAMPLE_W-1:0] ram_rd_data;

  localparam logic [1:0] MSEL_NONE  = 2'd0;
  localparam logic [1:0] MSEL_VOL   = 2'd1;
  localparam logic [1:0] MSEL_LEFT  = 2'd2;
  localparam logic [1:0] MSEL_RIGHT = 2'd3;

  svm_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(SAMPLE_DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(in_data.load_value),
    .rd_en  (ram_rd_en),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  assign in_xfer   = in_valid && !in_stall;
  assign cfg_xfer  = cfg_valid && cfg_ready;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // play decision and position advance
  assign pos_int  = pos_r[POS_W-1:FRACTION_BITS];
  assign at_end   = pos_int >= length_r;
  assign run      = active_r && !pause_r;
  assign mix_stop = run && at_end && !loop_r;
  assign mix_go   = run && !mix_stop;
  assign pos_base = (at_end && loop_r) ? '0 : pos_r;
  assign idx_ext  = IDX_EXT_W'(pos_base[POS_W-1:FRACTION_BITS]);
  assign lda_ext  = LDA_EXT_W'(in_data.load_address);

  assign pitch_c = (pitch_r < PITCH_MIN) ? PITCH_MIN :
                   (pitch_r > PITCH_MAX) ? PITCH_MAX : pitch_r;
  assign step_fx = (STEP_W'(pitch_c) << STEP_UP) >> STEP_DOWN;
  assign pos_sum = (POS_W + 1)'(pos_base) + (POS_W + 1)'(step_fx);
  assign pos_adv = pos_sum[POS_W] ? '1 : pos_sum[POS_W-1:0];

  assign vol_c = (volume_r > UNITY_VOLUME) ? UNITY_VOLUME : volume_r;
  assign lg_c  = (lgain_r > MAX_GAIN) ? MAX_GAIN : lgain_r;
  assign rg_c  = (rgain_r > MAX_GAIN) ? MAX_GAIN : rgain_r;

  assign ram_wr_addr = lda_ext[ADDR_W-1:0];
  assign ram_rd_addr = idx_ext[ADDR_W-1:0];

  // shared multiplier
  always_comb begin
    case (mul_sel)
      MSEL_VOL: begin
        mul_a = signed'({ram_rd_data[SAMPLE_W-1], ram_rd_data});
        mul_b = signed'({1'b0, vol_c});
      end
      MSEL_LEFT: begin
        mul_a = scaled_r;
        mul_b = signed'({1'b0, lg_c});
      end
      MSEL_RIGHT: begin
        mul_a = scaled_r;
        mul_b = signed'({1'b0, rg_c});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p    = mul_a * mul_b;
  assign side_sum = SUM_W'((state_r == S_FINISH) ? right_r : left_r) +
                    SUM_W'(trunc_q(prod_r, GAIN_SHIFT));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_data.action == ACT_MIX && mix_go) ? S_VOL : S_DONE;
        end
      end
      S_VOL:    state_nxt = S_SCALE;
      S_SCALE:  state_nxt = S_LEFT;
      S_LEFT:   state_nxt = S_RIGHT;
      S_RIGHT:  state_nxt = S_FINISH;
      S_FINISH: state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall  = 1'b1;
    cfg_ready = 1'b0;
    mul_sel   = MSEL_NONE;
    ram_wr_en = 1'b0;
    ram_rd_en = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_stall  = 1'b0;
        cfg_ready = 1'b1;
        ram_wr_en = in_valid && in_data.action == ACT_LOAD &&
                    32'(in_data.load_address) < 32'(SAMPLE_DEPTH);
        ram_rd_en = in_valid && in_data.action == ACT_MIX;
      end
      S_VOL:   mul_sel = MSEL_VOL;
      S_LEFT:  mul_sel = MSEL_LEFT;
      S_RIGHT: mul_sel = MSEL_RIGHT;
      default: mul_sel = MSEL_NONE;
    endcase
  end

  // datapath and voice state
  always_comb begin
    pos_nxt       = pos_r;
    active_nxt    = active_r;
    volume_nxt    = volume_r;
    pitch_nxt     = pitch_r;
    lgain_nxt     = lgain_r;
    rgain_nxt     = rgain_r;
    length_nxt    = length_r;
    loop_nxt      = loop_r;
    pause_nxt     = pause_r;
    prod_nxt      = prod_r;
    scaled_nxt    = scaled_r;
    left_nxt      = left_r;
    right_nxt     = right_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    if (cfg_xfer) begin
      case (cfg_index)
        CFG_VOLUME:     volume_nxt = cfg_data[15:0];
        CFG_PITCH_STEP: pitch_nxt  = cfg_data[PITCH_W-1:0];
        CFG_LEFT_GAIN:  lgain_nxt  = cfg_data[15:0];
        CFG_RIGHT_GAIN: rgain_nxt  = cfg_data[15:0];
        CFG_LENGTH:     length_nxt = cfg_data[INT_W-1:0];
        CFG_LOOP:       loop_nxt   = cfg_data[0];
        CFG_PAUSE:      pause_nxt  = cfg_data[0];
        default: ;
      endcase
    end

    if (in_xfer) begin
      left_nxt  = '0;
      right_nxt = '0;
      case (in_data.action)
        ACT_START: begin
          pos_nxt    = '0;
          active_nxt = 1'b1;
        end
        ACT_HALT: active_nxt = 1'b0;
        ACT_MIX: begin
          left_nxt  = in_data.left_in;
          right_nxt = in_data.right_in;
          if (mix_stop) begin
            active_nxt = 1'b0;
          end
          if (mix_go) begin
            pos_nxt = pos_adv;
          end
        end
        default: ;
      endcase
    end

    case (state_r)
      S_VOL:    prod_nxt   = mul_p;
      S_SCALE:  scaled_nxt = MUL_W'(trunc_q(prod_r, VOL_SHIFT));
      S_LEFT:   prod_nxt   = mul_p;
      S_RIGHT: begin
        left_nxt = sat16(side_sum);
        prod_nxt = mul_p;
      end
      S_FINISH: right_nxt  = sat16(side_sum);
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.left_out  = left_r;
          out_data_nxt.right_out = right_r;
          out_data_nxt.playing   = active_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      active_r    <= 1'b0;
      volume_r    <= VOLUME_RST;
      pitch_r     <= PITCH_RST;
      lgain_r     <= GAIN_RST;
      rgain_r     <= GAIN_RST;
      length_r    <= '0;
      loop_r      <= 1'b0;
      pause_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      active_r    <= active_nxt;
      volume_r    <= volume_nxt;
      pitch_r     <= pitch_nxt;
      lgain_r     <= lgain_nxt;
      rgain_r     <= rgain_nxt;
      length_r    <= length_nxt;
      loop_r      <= loop_nxt;
      pause_r     <= pause_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r     <= prod_nxt;
    scaled_r   <= scaled_nxt;
    left_r     <= left_nxt;
    right_r    <= right_nxt;
    out_data_r <= out_data_nxt;
  end

  `SVM_ASSERT_NEXT(a_mix_runs, in_xfer && in_data.action == ACT_MIX && mix_go,
                   state_r == S_VOL, "playing mix item did not enter the multiply sequence")
  `SVM_ASSERT_NEXT(a_voice_hold, state_r != S_IDLE,
                   $stable(pos_r) && $stable(active_r), "voice state changed mid item")
  `SVM_ASSERT_NEXT(a_stop_clears, in_xfer && in_data.action == ACT_MIX && mix_stop,
                   !active_r, "voice still active after reaching the end")
  `SVM_ASSERT_NEXT(a_done_loads, state_r == S_DONE && out_free,
                   out_valid_r && state_r == S_IDLE, "finished result not registered")
  `SVM_ASSERT_NOW(a_busy_no_cfg, state_r != S_IDLE,
                  !cfg_ready && in_stall, "busy sequencer opened a channel")

endmodule
